// File: src/lfw_pkg.sv
// shared types and constants for the line-following waterer
package lfw_pkg;

   localparam int READING_BITS_DEFAULT = 8;

   localparam int DATA_BITS = 9;
   localparam int DUTY_BITS = 10;
   localparam int MARK_BITS = 5;

   localparam logic [7:0] THRESHOLD_RESET = 8'd70;
   localparam logic [8:0] LEFT_BASE_RESET = 9'd420;
   localparam logic [8:0] RIGHT_BASE_RESET = 9'd450;
   localparam logic [7:0] GAIN_RESET = 8'd50;

   localparam int STEER_DIVISOR = 500;
   localparam logic [7:0] CMD_OFFSET = 8'd33;
   localparam logic [MARK_BITS-1:0] MARK_COUNT_MAX = 5'd31;
   localparam int DUTY_MAX = 1023;
   localparam logic [1:0] PUMP_ON_UNITS = 2'd3;
   localparam logic [1:0] PUMP_OFF_UNITS = 2'd2;
   localparam logic [3:0] LEVEL_MAX_WATERED = 4'd2;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_LEFT_BASE = 2'd1,
      CSR_RIGHT_BASE = 2'd2,
      CSR_GAIN = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_CMD = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_TICK = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      DRV_STOP = 2'd0,
      DRV_FWD = 2'd1,
      DRV_BACK = 2'd2
   } drive_type;

   typedef enum logic [1:0] {
      DUTY_HOLD = 2'd0,
      DUTY_BASE = 2'd1,
      DUTY_STEER = 2'd2
   } duty_op_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_SEEK = 5'b00010,
      PH_PUMP_ON = 5'b00100,
      PH_PUMP_OFF = 5'b01000,
      PH_RETURN = 5'b10000
   } phase_type;

   // status handed from the control stage to the duty stage
   typedef struct packed {
      drive_type drive_mode;
      logic pump_on;
      logic busy;
      logic ack;
      logic [MARK_BITS-1:0] marks;
      duty_op_type duty_op;
      logic flip;
   } stage_ctrl_type;

endpackage

// File: src/lfw_ctrl.sv
// phase sequencer, mark counting and steering product stage
module lfw_ctrl
   import lfw_pkg::*;
#(
   parameter int READING_BITS = READING_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [1:0] action,
   input  logic [7:0] command_byte,
   input  logic [READING_BITS-1:0] left_reading,
   input  logic [READING_BITS-1:0] center_reading,
   input  logic [READING_BITS-1:0] right_reading,
   input  logic [7:0] threshold,
   input  logic [7:0] gain,
   output stage_ctrl_type stage_ctrl,
   output logic [READING_BITS+7:0] prod_mag
);

   phase_type phase_ff, phase_in;
   logic on_mark_ff, on_mark_in;
   logic [MARK_BITS-1:0] mark_count_ff, mark_count_in;
   logic [3:0] target_ff, target_in;
   logic [3:0] level_ff, level_in;
   logic [1:0] unit_count_ff, unit_count_in;
   drive_type drive_ff, drive_in;
   logic ack_ff, ack_in;
   duty_op_type duty_op_ff, duty_op_in;
   logic flip_ff, flip_in;
   logic [READING_BITS+7:0] prod_ff, prod_in;

   logic [READING_BITS-1:0] thr_ext;
   logic [READING_BITS-1:0] diff_mag;
   logic diff_neg;
   logic mark;
   logic [7:0] cmd_val;
   logic [1:0] unit_next;
   action_type act;

   assign thr_ext = READING_BITS'(threshold);
   assign mark = (left_reading > thr_ext) && (center_reading > thr_ext)
      && (right_reading > thr_ext);
   assign diff_neg = left_reading > right_reading;
   assign diff_mag = diff_neg ? (left_reading - right_reading)
                              : (right_reading - left_reading);
   assign cmd_val = command_byte - CMD_OFFSET;
   assign unit_next = unit_count_ff + 2'd1;
   assign act = action_type'(action);

   always_comb begin
      phase_in = phase_ff;
      on_mark_in = on_mark_ff;
      mark_count_in = mark_count_ff;
      target_in = target_ff;
      level_in = level_ff;
      unit_count_in = unit_count_ff;
      drive_in = drive_ff;
      ack_in = 1'b0;
      duty_op_in = DUTY_HOLD;
      flip_in = diff_neg ^ (phase_ff == PH_RETURN);
      prod_in = (READING_BITS + 8)'(diff_mag) * (READING_BITS + 8)'(gain);
      unique case (act)
         ACT_CMD: begin
            if (phase_ff == PH_IDLE) begin
               target_in = cmd_val[7:4];
               level_in = cmd_val[3:0];
               mark_count_in = '0;
               on_mark_in = 1'b0;
               unit_count_in = '0;
               duty_op_in = DUTY_BASE;
               drive_in = DRV_FWD;
               phase_in = PH_SEEK;
            end
         end
         ACT_SAMPLE: begin
            if (phase_ff == PH_SEEK || phase_ff == PH_RETURN) begin
               if (on_mark_ff) begin
                  // leaving a mark never steers
                  if (!mark) begin
                     on_mark_in = 1'b0;
                     if (phase_ff == PH_SEEK && mark_count_ff > MARK_BITS'(target_ff)) begin
                        drive_in = DRV_STOP;
                        unit_count_in = '0;
                        if (level_ff <= LEVEL_MAX_WATERED) begin
                           phase_in = PH_PUMP_ON;
                        end else begin
                           phase_in = PH_RETURN;
                           duty_op_in = DUTY_BASE;
                           drive_in = DRV_BACK;
                        end
                     end else if (phase_ff == PH_RETURN && mark_count_ff == '0) begin
                        drive_in = DRV_STOP;
                        phase_in = PH_IDLE;
                        ack_in = 1'b1;
                     end
                  end
               end else begin
                  duty_op_in = DUTY_STEER;
                  if (mark) begin
                     on_mark_in = 1'b1;
                     if (phase_ff == PH_SEEK) begin
                        if (mark_count_ff < MARK_COUNT_MAX) begin
                           mark_count_in = mark_count_ff + 5'd1;
                        end
                     end else if (mark_count_ff != '0) begin
                        mark_count_in = mark_count_ff - 5'd1;
                     end
                  end
               end
            end
         end
         ACT_TICK: begin
            if (phase_ff == PH_PUMP_ON) begin
               unit_count_in = unit_next;
               if (unit_next >= PUMP_ON_UNITS - level_ff[1:0]) begin
                  unit_count_in = '0;
                  phase_in = PH_PUMP_OFF;
               end
            end else if (phase_ff == PH_PUMP_OFF) begin
               unit_count_in = unit_next;
               if (unit_next >= PUMP_OFF_UNITS) begin
                  unit_count_in = '0;
                  phase_in = PH_RETURN;
                  duty_op_in = DUTY_BASE;
                  drive_in = DRV_BACK;
                  on_mark_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         on_mark_ff <= 1'b0;
         mark_count_ff <= '0;
         target_ff <= '0;
         level_ff <= '0;
         unit_count_ff <= '0;
         drive_ff <= DRV_STOP;
         ack_ff <= 1'b0;
         duty_op_ff <= DUTY_HOLD;
      end else if (advance) begin
         phase_ff <= phase_in;
         on_mark_ff <= on_mark_in;
         mark_count_ff <= mark_count_in;
         target_ff <= target_in;
         level_ff <= level_in;
         unit_count_ff <= unit_count_in;
         drive_ff <= drive_in;
         ack_ff <= ack_in;
         duty_op_ff <= duty_op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flip_ff <= flip_in;
         prod_ff <= prod_in;
      end
   end

   assign stage_ctrl.drive_mode = drive_ff;
   assign stage_ctrl.pump_on = (phase_ff == PH_PUMP_ON);
   assign stage_ctrl.busy = (phase_ff != PH_IDLE);
   assign stage_ctrl.ack = ack_ff;
   assign stage_ctrl.marks = mark_count_ff;
   assign stage_ctrl.duty_op = duty_op_ff;
   assign stage_ctrl.flip = flip_ff;
   assign prod_mag = prod_ff;

endmodule

// File: src/lfw_duty.sv
// steering correction divide and duty saturation
module lfw_duty
   import lfw_pkg::*;
#(
   parameter int READING_BITS = READING_BITS_DEFAULT
) (
   input  stage_ctrl_type stage_ctrl,
   input  logic [READING_BITS+7:0] prod_mag,
   input  logic [8:0] left_base,
   input  logic [8:0] right_base,
   input  logic [DUTY_BITS-1:0] left_duty,
   input  logic [DUTY_BITS-1:0] right_duty,
   output logic [DUTY_BITS-1:0] left_duty_next,
   output logic [DUTY_BITS-1:0] right_duty_next
);

   localparam int PROD_BITS = READING_BITS + 8;
   localparam int DIV_SHIFT = PROD_BITS + $clog2(STEER_DIVISOR);
   localparam int RECIP_BITS = PROD_BITS + 1;
   localparam int WIDE_BITS = PROD_BITS + RECIP_BITS;
   localparam int SUM_BITS = READING_BITS + 3;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << DIV_SHIFT) + STEER_DIVISOR - 1) / STEER_DIVISOR;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

   logic [WIDE_BITS-1:0] recip_prod;
   logic [READING_BITS-1:0] quot;
   logic signed [SUM_BITS-1:0] quot_s, lbase_s, rbase_s, lsum, rsum;

   function automatic logic [DUTY_BITS-1:0] clamp_duty(input logic signed [SUM_BITS-1:0] v);
      logic [DUTY_BITS-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > SUM_BITS'(DUTY_MAX)) begin
         res = DUTY_BITS'(DUTY_MAX);
      end else begin
         res = v[DUTY_BITS-1:0];
      end
      return res;
   endfunction

   // exact floor of the magnitude over the divisor by scaled reciprocal
   assign recip_prod = WIDE_BITS'(prod_mag) * WIDE_BITS'(RECIP);
   assign quot = recip_prod[DIV_SHIFT +: READING_BITS];

   assign quot_s = SUM_BITS'(quot);
   assign lbase_s = SUM_BITS'(left_base);
   assign rbase_s = SUM_BITS'(right_base);
   assign lsum = stage_ctrl.flip ? (lbase_s + quot_s) : (lbase_s - quot_s);
   assign rsum = stage_ctrl.flip ? (rbase_s - quot_s) : (rbase_s + quot_s);

   always_comb begin
      unique case (stage_ctrl.duty_op)
         DUTY_BASE: begin
            left_duty_next = DUTY_BITS'(left_base);
            right_duty_next = DUTY_BITS'(right_base);
         end
         DUTY_STEER: begin
            left_duty_next = clamp_duty(lsum);
            right_duty_next = clamp_duty(rsum);
         end
         default: begin
            left_duty_next = left_duty;
            right_duty_next = right_duty;
         end
      endcase
   end

endmodule

// File: src/line_follow_mark_counting_waterer_unit.sv
// top level of the line-following mark-counting waterer controller
//
//   channel   direction   handshake           carries
//   req_      in          req_valid/stall     action, command byte, three readings
//   rsp_      out         rsp_valid/stall     duties, drive mode, pump, busy, ack, marks
//   csr_      in          csr_valid/ready     register index and write data
//
// one request per cycle sustained while rsp_stall is low; its result is registered in turn in
// the input register, the control stage and the result register
// the control stage holds the multiplier, the result stage the reciprocal divide
// reset clears all phase and count state, duties to zero, registers to defaults
// a stalled result holds; requests are still taken while a later stage is empty
module line_follow_mark_counting_waterer_unit
   import lfw_pkg::*;
#(
   parameter int READING_BITS = READING_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_command_byte,
   input  logic [READING_BITS-1:0] req_left_reading,
   input  logic [READING_BITS-1:0] req_center_reading,
   input  logic [READING_BITS-1:0] req_right_reading,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [DUTY_BITS-1:0] rsp_left_duty,
   output logic [DUTY_BITS-1:0] rsp_right_duty,
   output logic [1:0] rsp_drive_mode,
   output logic rsp_pump_on,
   output logic rsp_busy_res,
   output logic rsp_ack,
   output logic [MARK_BITS-1:0] rsp_marks_passed,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [DATA_BITS-1:0] csr_data
);

   logic [7:0] threshold_ff;
   logic [8:0] left_base_ff;
   logic [8:0] right_base_ff;
   logic [7:0] gain_ff;

   logic in_valid_ff;
   logic [1:0] in_action_ff;
   logic [7:0] in_byte_ff;
   logic [READING_BITS-1:0] in_left_ff, in_center_ff, in_right_ff;

   logic mid_valid_ff;
   logic out_valid_ff;
   logic [DUTY_BITS-1:0] left_duty_ff, right_duty_ff, left_duty_in, right_duty_in;
   drive_type drive_ff;
   logic pump_ff, busy_ff, ack_ff;
   logic [MARK_BITS-1:0] marks_ff;

   logic out_ready, mid_ready, in_ready;
   logic accept, move_mid, move_out;
   stage_ctrl_type stage_ctrl;
   logic [READING_BITS+7:0] prod_mag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         left_base_ff <= LEFT_BASE_RESET;
         right_base_ff <= RIGHT_BASE_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_data[7:0];
            CSR_LEFT_BASE: left_base_ff <= csr_data[8:0];
            CSR_RIGHT_BASE: right_base_ff <= csr_data[8:0];
            CSR_GAIN: gain_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // each stage loads when empty or when its content moves on
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign in_ready = !in_valid_ff || mid_ready;
   assign req_stall = !in_ready;
   assign accept = req_valid && in_ready;
   assign move_mid = in_valid_ff && mid_ready;
   assign move_out = mid_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (move_mid) begin
            in_valid_ff <= 1'b0;
         end
         if (move_mid) begin
            mid_valid_ff <= 1'b1;
         end else if (move_out) begin
            mid_valid_ff <= 1'b0;
         end
         if (move_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_byte_ff <= req_command_byte;
         in_left_ff <= req_left_reading;
         in_center_ff <= req_center_reading;
         in_right_ff <= req_right_reading;
      end
   end

   lfw_ctrl #(
      .READING_BITS(READING_BITS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .advance(move_mid),
      .action(in_action_ff),
      .command_byte(in_byte_ff),
      .left_reading(in_left_ff),
      .center_reading(in_center_ff),
      .right_reading(in_right_ff),
      .threshold(threshold_ff),
      .gain(gain_ff),
      .stage_ctrl(stage_ctrl),
      .prod_mag(prod_mag)
   );

   lfw_duty #(
      .READING_BITS(READING_BITS)
   ) u_duty (
      .stage_ctrl(stage_ctrl),
      .prod_mag(prod_mag),
      .left_base(left_base_ff),
      .right_base(right_base_ff),
      .left_duty(left_duty_ff),
      .right_duty(right_duty_ff),
      .left_duty_next(left_duty_in),
      .right_duty_next(right_duty_in)
   );

   // the result register also holds the duty state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_duty_ff <= '0;
         right_duty_ff <= '0;
         drive_ff <= DRV_STOP;
         pump_ff <= 1'b0;
         busy_ff <= 1'b0;
         ack_ff <= 1'b0;
         marks_ff <= '0;
      end else if (move_out) begin
         left_duty_ff <= left_duty_in;
         right_duty_ff <= right_duty_in;
         drive_ff <= stage_ctrl.drive_mode;
         pump_ff <= stage_ctrl.pump_on;
         busy_ff <= stage_ctrl.busy;
         ack_ff <= stage_ctrl.ack;
         marks_ff <= stage_ctrl.marks;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_left_duty = left_duty_ff;
   assign rsp_right_duty = right_duty_ff;
   assign rsp_drive_mode = drive_ff;
   assign rsp_pump_on = pump_ff;
   assign rsp_busy_res = busy_ff;
   assign rsp_ack = ack_ff;
   assign rsp_marks_passed = marks_ff;

   a_ack_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack |-> !rsp_busy_res)
      else $error("ack reported while a job is still in progress");

   a_pump_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pump_on |-> rsp_busy_res && rsp_drive_mode == DRV_STOP)
      else $error("pump running while driving or idle");

   a_idle_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_drive_mode == DRV_STOP)
      else $error("wheels driven while idle");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && mid_valid_ff && out_valid_ff)
      else $error("request stalled with an empty stage");

endmodule
